// ===== sv/slrg_pkg.sv =====
// Shared constants and codes for the shuffled Lehmer random generator.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package slrg_pkg;

  // Shuffle table geometry
  localparam int unsigned TABLE_SIZE = 32;
  localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
  localparam int unsigned INIT_STEPS = TABLE_SIZE + 8;
  localparam int unsigned CNT_W      = $clog2(INIT_STEPS);

  // Field and datapath widths
  localparam int unsigned SEED_W = 32;
  localparam int unsigned VAL_W  = 31;
  localparam int unsigned MULT_W = 15;
  localparam int unsigned PROD_W = VAL_W + MULT_W;

  // Generator constants
  localparam logic [MULT_W-1:0] LCG_MULT = MULT_W'(16807);
  localparam logic [VAL_W-1:0]  LCG_MOD  = 31'h7FFF_FFFF;

  // Divisor that maps an output value onto a table index
  localparam logic [SEED_W-1:0] TABLE_DIV =
    SEED_W'(64'd1 + (64'h7FFF_FFFE / 64'(TABLE_SIZE)));

  // Reseed constants
  localparam logic [SEED_W-1:0] RESEED_OFS = 32'd22261048;
  localparam logic signed [SEED_W-1:0] RESEED_LIM = 32'sd1000;

  // Request kinds carried in tuser
  localparam logic FUNC_DRAW   = 1'b0;
  localparam logic FUNC_RESEED = 1'b1;

endpackage

`default_nettype wire

// ===== sv/slrg_mulmod.sv =====
// Lehmer step unit: registered multiply by 16807, then reduction mod 2^31-1.
// Depends on slrg_pkg for widths and constants.
`default_nettype none

module slrg_mulmod (
  input  wire logic                       clk_i,
  input  wire logic                       mul_en_i,
  input  wire logic [slrg_pkg::VAL_W-1:0] seed_i,
  output logic      [slrg_pkg::VAL_W-1:0] next_seed_o
);

  logic [slrg_pkg::PROD_W-1:0] prod_q;
  logic [slrg_pkg::VAL_W:0]    fold;

  // Capture the product
  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= slrg_pkg::PROD_W'(seed_i) * slrg_pkg::PROD_W'(slrg_pkg::LCG_MULT);
    end
  end

  // Fold high part onto low part; one subtract brings it below the modulus
  always_comb begin
    fold = {1'b0, prod_q[slrg_pkg::VAL_W-1:0]}
         + (slrg_pkg::VAL_W+1)'(prod_q[slrg_pkg::PROD_W-1:slrg_pkg::VAL_W]);
    if (fold >= {1'b0, slrg_pkg::LCG_MOD}) begin
      next_seed_o = slrg_pkg::VAL_W'(fold - {1'b0, slrg_pkg::LCG_MOD});
    end else begin
      next_seed_o = fold[slrg_pkg::VAL_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/shuffled_lehmer_random_generator_unit.sv =====
// Top level of the shuffled Lehmer random generator: control, shuffle table RAM.
// Depends on slrg_pkg and slrg_mulmod.
//
//  Channel   Dir  Handshake               Payload
//  s_axis    in   tvalid/tready           tuser = func, tdata = seed_time
//  m_axis    out  tvalid/tready           tdata = random_value (zero-padded)
//
// A reseed request only loads the seed and gives no result.
// A draw does multiply plus table read, then reduce plus table write.
// A draw that must re-initialise first runs forty Lehmer steps through the shared
// multiplier, the last table-size of them writing the table RAM, then the draw.
// Reset clears seed and last output, so the first draw re-initialises; the
// table RAM needs no clearing. A held result stalls the next draw in its last cycle.
`default_nettype none

module shuffled_lehmer_random_generator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [31:0] seed_time
  input  wire logic        s_axis_tuser,  // [0] func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata   // [30:0] random_value, [31] zero
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_RED  = 2'd2;

  localparam int unsigned SW = slrg_pkg::SEED_W;
  localparam int unsigned VW = slrg_pkg::VAL_W;
  localparam int unsigned IW = slrg_pkg::IDX_W;
  localparam int unsigned CW = slrg_pkg::CNT_W;

  logic [1:0]    state_q, state_d;
  logic [SW-1:0] seed_q, seed_d;
  logic [VW-1:0] last_q, last_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          init_q, init_d;
  logic [IW-1:0] idx_q;
  logic          out_valid_q, out_valid_d;
  logic [VW-1:0] out_data_q, out_data_d;
  logic [VW-1:0] rd_q;

  logic [VW-1:0] table_mem [slrg_pkg::TABLE_SIZE];

  logic          accept;
  logic          need_init;
  logic [SW-1:0] seed_neg, init_seed;
  logic [SW-1:0] t_neg, reseed_val;
  logic [SW-1:0] quot;
  logic [IW-1:0] idx;
  logic          mul_en, rd_en, wr_en;
  logic [IW-1:0] wr_addr;
  logic [VW-1:0] next_seed;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_data_q};

  // Re-initialisation check and the start seed it uses
  assign need_init = ($signed(seed_q) <= 0) || (last_q == '0);
  assign seed_neg  = '0 - seed_q;
  assign init_seed = ($signed(seed_neg) < 1) ? SW'(1) : seed_neg;

  // Reseed from the time value
  always_comb begin
    t_neg = '0 - s_axis_tdata;
    if ($signed(t_neg) > slrg_pkg::RESEED_LIM) begin
      reseed_val = '0 - t_neg;
    end else if ($signed(t_neg) > -slrg_pkg::RESEED_LIM) begin
      reseed_val = t_neg - slrg_pkg::RESEED_OFS;
    end else begin
      reseed_val = t_neg;
    end
  end

  // Table index from the previous output, clamped to the table
  always_comb begin
    quot = {1'b0, last_q} / slrg_pkg::TABLE_DIV;
    if (quot >= SW'(slrg_pkg::TABLE_SIZE)) begin
      idx = IW'(slrg_pkg::TABLE_SIZE - 1);
    end else begin
      idx = quot[IW-1:0];
    end
  end

  // Shared Lehmer step
  slrg_mulmod u_mulmod (
    .clk_i       (clk_i),
    .mul_en_i    (mul_en),
    .seed_i      (seed_q[VW-1:0]),
    .next_seed_o (next_seed)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    seed_d      = seed_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    init_d      = init_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mul_en      = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = idx_q;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == slrg_pkg::FUNC_RESEED) begin
            seed_d = reseed_val;
          end else if (need_init) begin
            seed_d  = init_seed;
            init_d  = 1'b1;
            cnt_d   = CW'(slrg_pkg::INIT_STEPS - 1);
            state_d = ST_MUL;
          end else begin
            mul_en  = 1'b1;
            rd_en   = 1'b1;
            state_d = ST_RED;
          end
        end
      end
      ST_MUL: begin
        mul_en  = 1'b1;
        rd_en   = !init_q;
        state_d = ST_RED;
      end
      ST_RED: begin
        if (init_q) begin
          // Warm-up step: the last table-size seeds fill the table downwards
          seed_d  = SW'(next_seed);
          wr_en   = (cnt_q < CW'(slrg_pkg::TABLE_SIZE));
          wr_addr = cnt_q[IW-1:0];
          state_d = ST_MUL;
          if (cnt_q == '0) begin
            last_d = next_seed;
            init_d = 1'b0;
          end else begin
            cnt_d = cnt_q - CW'(1);
          end
        end else if (!out_valid_q || m_axis_tready) begin
          // Swap: old entry goes out, new seed takes its place
          seed_d      = SW'(next_seed);
          wr_en       = 1'b1;
          last_d      = rd_q;
          out_valid_d = 1'b1;
          out_data_d  = rd_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= '0;
      last_q      <= '0;
      cnt_q       <= '0;
      init_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seed_q      <= seed_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (rd_en) begin
      idx_q <= idx;
    end
  end

  // Shuffle table RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[wr_addr] <= next_seed;
    end
    if (rd_en) begin
      rd_q <= table_mem[idx];
    end
  end

  // Checks
  a_mul_seed_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_en |-> !seed_q[SW-1])
    else $error("multiplier fed a negative seed");

  a_reduced_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RED) |-> (next_seed != slrg_pkg::LCG_MOD))
    else $error("reduction left the modulus itself");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> (cnt_q <= CW'(slrg_pkg::INIT_STEPS - 1)))
    else $error("warm-up counter out of range");

  a_draw_waits_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RED && !init_q && out_valid_q && !m_axis_tready)
    |=> (state_q == ST_RED))
    else $error("draw finished while the result slot was full");

  a_no_read_during_warmup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> !rd_en)
    else $error("table read issued during warm-up");

endmodule

`default_nettype wire

// ===== verif/lehmer_draw_checker.sv =====
// Checker for the shuffled Lehmer random generator: watches both streams,
// predicts each draw from its own copy of seed, last output and shuffle table,
// and compares every result. Depends on slrg_pkg for the table size and the request codes.
module lehmer_draw_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [31:0] s_axis_tdata_i,  // [31:0] seed_time
  input  wire logic        s_axis_tuser_i,  // [0] func
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [31:0] m_axis_tdata_i,  // [30:0] random_value, [31] zero
  output int               mismatches_o,
  output int               pending_o,
  output int               results_o,
  output int               draws_o,
  output int               reseeds_o,
  output int               refills_o
);

  localparam int unsigned DEPTH       = slrg_pkg::TABLE_SIZE;
  localparam logic [63:0] MINSTD_MULT = 64'd16807;
  localparam logic [63:0] MINSTD_MOD  = 64'd2147483647;
  localparam logic [31:0] SLOT_DIV    = 32'd1 + 32'd2147483646 / 32'(DEPTH);
  localparam logic [31:0] RESEED_SHIFT = 32'd22261048;
  localparam logic signed [31:0] RESEED_BAND = 32'sd1000;

  // Predicted generator state
  logic [31:0] seed_q;
  logic [30:0] last_q;
  logic [30:0] shuffle_q [DEPTH];

  // Results still owed by the block, oldest first
  logic [30:0] expected_draws [$];

  int mismatch_count;
  int result_count;
  int draw_count;
  int reseed_count;
  int refill_count;

  function automatic logic [31:0] lehmer_step(input logic [31:0] s);
    logic [63:0] prod;
    prod = 64'(s) * MINSTD_MULT;
    return 32'(prod % MINSTD_MOD);
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch: %s got 0x%08h want 0x%08h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Refill the table from a fresh seed and forty warm-up steps
  task automatic refill_table();
    logic [31:0] neg;
    neg = 32'd0 - seed_q;
    seed_q = ($signed(neg) < 32'sd1) ? 32'd1 : neg;
    for (int n = DEPTH + 7; n >= 0; n--) begin
      seed_q = lehmer_step(seed_q);
      if (n < DEPTH) shuffle_q[n] = seed_q[30:0];
    end
    last_q = shuffle_q[0];
    refill_count++;
  endtask

  // Apply one accepted request to the predicted state
  task automatic predict_request(input logic func, input logic [31:0] stamp);
    logic [31:0] cand;
    logic [31:0] slot;
    if (func == slrg_pkg::FUNC_RESEED) begin
      cand = 32'd0 - stamp;
      if ($signed(cand) > RESEED_BAND) cand = 32'd0 - cand;
      else if ($signed(cand) > -RESEED_BAND) cand = cand - RESEED_SHIFT;
      seed_q = cand;
      reseed_count++;
    end else begin
      if ($signed(seed_q) <= 32'sd0 || last_q == 31'd0) refill_table();
      seed_q = lehmer_step(seed_q);
      slot = {1'b0, last_q} / SLOT_DIV;
      if (slot >= 32'(DEPTH)) slot = 32'(DEPTH - 1);
      last_q = shuffle_q[slot];
      shuffle_q[slot] = seed_q[30:0];
      expected_draws.push_back(last_q);
      draw_count++;
    end
  endtask

  // Compare one accepted result with the oldest prediction
  task automatic check_result(input logic [31:0] word);
    logic [30:0] want;
    if (expected_draws.size() == 0) begin
      report_mismatch("result with no draw pending", word, 32'd0);
    end else begin
      want = expected_draws.pop_front();
      if (word[30:0] !== want) report_mismatch("random_value", {1'b0, word[30:0]}, {1'b0, want});
      if (word[31] !== 1'b0) report_mismatch("tdata padding", {31'd0, word[31]}, 32'd0);
    end
    result_count++;
  endtask

  // Retire results before predicting: a result never belongs to a request
  // accepted on the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q = 32'd0;
      last_q = 31'd0;
      for (int i = 0; i < DEPTH; i++) shuffle_q[i] = 31'd0;
      expected_draws.delete();
      mismatch_count = 0;
      result_count   = 0;
      draw_count     = 0;
      reseed_count   = 0;
      refill_count   = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_result(m_axis_tdata_i);
      if (s_axis_tvalid_i && s_axis_tready_i) predict_request(s_axis_tuser_i, s_axis_tdata_i);
    end
    pending_o    <= expected_draws.size();
    mismatches_o <= mismatch_count;
    results_o    <= result_count;
    draws_o      <= draw_count;
    reseeds_o    <= reseed_count;
    refills_o    <= refill_count;
  end

endmodule

// ===== verif/shuffled_lehmer_random_generator_unit_test.sv =====
// Testbench top for the shuffled Lehmer random generator: clock, reset,
// request stimulus under several idling phases and the final verdict.
// Depends on slrg_pkg, the generator unit and lehmer_draw_checker.
module shuffled_lehmer_random_generator_unit_test;

  typedef enum int {
    PH_FLOW,
    PH_SRC_IDLE,
    PH_SINK_STALL,
    PH_BOTH_IDLE,
    PH_BACKLOG
  } phase_e;

  localparam int ITEMS_PER_PHASE = 310;
  localparam int BACKLOG_HOLD    = 400;
  localparam int TAIL_CYCLES     = 120;
  localparam int LIMIT_CYCLES    = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] seed_time
  logic        s_axis_tuser;   // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [30:0] random_value, [31] zero

  phase_e phase = PH_FLOW;
  logic   backlog_done = 1'b0;
  int     cycle_count = 0;

  int mismatches;
  int pending_draws;
  int results_seen;
  int draws_sent;
  int reseeds_sent;
  int refills_seen;

  shuffled_lehmer_random_generator_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  lehmer_draw_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .mismatches_o    (mismatches),
    .pending_o       (pending_draws),
    .results_o       (results_seen),
    .draws_o         (draws_sent),
    .reseeds_o       (reseeds_sent),
    .refills_o       (refills_seen)
  );

  // Free-running clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a run that never drains
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** shuffled_lehmer_random_generator_unit: FAILED **");
      $finish;
    end
  end

  function automatic logic source_rests();
    case (phase)
      PH_SRC_IDLE:  return $urandom_range(0, 99) < 88;
      PH_BOTH_IDLE: return $urandom_range(0, 99) < 19;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic logic sink_stalls();
    case (phase)
      PH_SINK_STALL: return $urandom_range(0, 99) < 88;
      PH_BOTH_IDLE:  return $urandom_range(0, 99) < 19;
      default:       return 1'b0;
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off at the start of the backlog phase
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (phase == PH_BACKLOG && !backlog_done) begin
        m_axis_tready <= 1'b0;
        repeat (BACKLOG_HOLD) @(posedge clk_i);
        backlog_done = 1'b1;
      end
      m_axis_tready <= !sink_stalls();
    end
  end

  // Offer one request after any idle gap and hold it until accepted
  task automatic send_request(input logic func, input logic [31:0] stamp);
    while (source_rests()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= stamp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Pause the sender until every predicted draw has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_draws != 0) @(posedge clk_i);
  endtask

  // Mostly draws; reseeds pick full-range, near-threshold or extreme time values
  task automatic send_random_request();
    logic [31:0] stamp;
    int pick;
    stamp = $urandom();
    if ($urandom_range(0, 99) < 6) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        stamp = 32'($urandom_range(0, 2200)) - 32'd1100;
      end else if (pick < 5) begin
        case ($urandom_range(0, 5))
          0:       stamp = 32'h8000_0000;
          1:       stamp = 32'h7FFF_FFFF;
          2:       stamp = 32'h8000_0001;
          3:       stamp = 32'd0;
          4:       stamp = 32'hFFFF_FFFF;
          default: stamp = 32'd1;
        endcase
      end
      send_request(slrg_pkg::FUNC_RESEED, stamp);
    end else begin
      send_request(slrg_pkg::FUNC_DRAW, stamp);
    end
  endtask

  // Threshold edges, sign extremes and the seed that lands on the modulus
  task automatic run_directed();
    // the first draw initialises from the reset seed
    send_request(slrg_pkg::FUNC_DRAW, 32'h0000_0000);
    send_request(slrg_pkg::FUNC_DRAW, 32'hFFFF_FFFF);
    send_request(slrg_pkg::FUNC_DRAW, 32'h5A5A_A5A5);
    // zero time falls inside the band and is offset
    send_request(slrg_pkg::FUNC_RESEED, 32'd0);
    send_request(slrg_pkg::FUNC_DRAW, 32'd0);
    // most negative time: negation wraps, refill falls back to seed 1
    send_request(slrg_pkg::FUNC_RESEED, 32'h8000_0000);
    send_request(slrg_pkg::FUNC_DRAW, 32'd0);
    // seed reaches the modulus: zero table, zero output, then recovery
    send_request(slrg_pkg::FUNC_RESEED, 32'h7FFF_FFFF);
    send_request(slrg_pkg::FUNC_DRAW, 32'd0);
    send_request(slrg_pkg::FUNC_DRAW, 32'd0);
    send_request(slrg_pkg::FUNC_DRAW, 32'd0);
    // band edges either side of the threshold
    send_request(slrg_pkg::FUNC_RESEED, -32'sd1000);
    send_request(slrg_pkg::FUNC_DRAW, 32'd0);
    send_request(slrg_pkg::FUNC_RESEED, 32'sd1000);
    send_request(slrg_pkg::FUNC_DRAW, 32'd0);
    send_request(slrg_pkg::FUNC_RESEED, -32'sd1001);
    send_request(slrg_pkg::FUNC_DRAW, 32'd0);
    send_request(slrg_pkg::FUNC_RESEED, 32'sd1001);
    send_request(slrg_pkg::FUNC_DRAW, 32'd0);
    // back-to-back reseeds, only the last counts
    send_request(slrg_pkg::FUNC_RESEED, 32'h1234_5678);
    send_request(slrg_pkg::FUNC_RESEED, 32'sd999);
    send_request(slrg_pkg::FUNC_DRAW, 32'd0);
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = slrg_pkg::FUNC_DRAW;
    s_axis_tdata  = 32'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    // one pass per idling pattern, draining between them
    for (int p = PH_FLOW; p <= PH_BACKLOG; p++) begin
      phase = phase_e'(p);
      repeat (ITEMS_PER_PHASE) send_random_request();
      drain();
    end

    // let any stray result surface
    phase = PH_FLOW;
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run covered %0d draws and %0d reseeds with %0d table refills;",
             draws_sent, reseeds_sent, refills_seen);
    $display("%0d results checked under free flow, idle, stall and backlog phases.",
             results_seen);
    if (mismatches == 0) begin
      $display("** shuffled_lehmer_random_generator_unit: PASSED **");
    end else begin
      $display("** shuffled_lehmer_random_generator_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/slrg_pkg.sv
sv/slrg_mulmod.sv
sv/shuffled_lehmer_random_generator_unit.sv
verif/lehmer_draw_checker.sv
verif/shuffled_lehmer_random_generator_unit_test.sv
